// ----- src/rgba_tile_plane_layout_codec_macros.svh -----
// assertion macros for the tile plane layout codec
// expects clk_i and rst_ni in the including module's scope
`ifndef RGBA_TILE_PLANE_LAYOUT_CODEC_MACROS_SVH
`define RGBA_TILE_PLANE_LAYOUT_CODEC_MACROS_SVH

// plain property, sampled on the clock, off during reset
`define RTPL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define RTPL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RTPL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rtpl_pkg.sv -----
// shared types and constants of the tile plane layout codec
// no dependencies
package rtpl_pkg;

  localparam int BLOCK_WIDTH = 256;
  localparam int ALPHA_ROWS  = 64;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 17;
  localparam int HEIGHT_W    = 9;
  localparam int COORD_W     = 8;
  localparam int MODE_W      = 3;
  localparam int BYTE_W      = 8;
  localparam int LANES       = 4;
  localparam int LANE_W      = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_WPIX  = 3'd0,
    MODE_RWORD = 3'd1,
    MODE_WWORD = 3'd2,
    MODE_RPIX  = 3'd3,
    MODE_CLEAR = 3'd4
  } mode_e;

  // one classified item as handed from front to back
  typedef struct packed {
    mode_e               op;
    logic                bad;       // pixel row out of the tile
    logic                in_range;  // encoded address inside the store
    logic [ADDR_W-1:0]   addr_a;    // colour word, or encoded word address
    logic [ADDR_W-1:0]   addr_b;    // alpha word
    logic [LANE_W-1:0]   lane;      // alpha byte within its word
    logic [DATA_W-1:0]   data;      // colour word, or encoded word
    logic [BYTE_W-1:0]   alpha;
  } cmd_t;

endpackage

// ----- src/rgba_tile_plane_layout_codec.sv -----
// top level of the rgba tile plane layout codec: config register, front, queue, back
// depends on rtpl_pkg, rtpl_front, rtpl_queue, rtpl_back
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_stall_o    mode, pix_x, pix_y, word_index, write_data
//   out       output     out_valid_o / out_stall_i  read_data, bad_position
//   cfg       input      cfg_valid_i / cfg_ready_o  cfg_data_i (block_height)
//
// encoded write ends in idle, pixel write and encoded read in step2, pixel read in step3:
// one ram port each for read and write, and a pixel read needs two reads in turn
// a clear item zeroes all (MaxBlockHeight+64)*256 words of the store, one word written per cycle
// after reset the same clearing pass runs with in stalled;
// the two entry queue takes items while the back end waits on a stalled result
module rgba_tile_plane_layout_codec #(
  parameter int MaxBlockHeight = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rtpl_pkg::MODE_W-1:0]   mode_i,
  input  logic [rtpl_pkg::COORD_W-1:0]  pix_x_i,
  input  logic [rtpl_pkg::COORD_W-1:0]  pix_y_i,
  input  logic [rtpl_pkg::ADDR_W-1:0]   word_index_i,
  input  logic [rtpl_pkg::DATA_W-1:0]   write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rtpl_pkg::DATA_W-1:0]   read_data_o,
  output logic                          bad_position_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rtpl_pkg::HEIGHT_W-1:0] cfg_data_i
);

  localparam int StoreWords = (MaxBlockHeight + rtpl_pkg::ALPHA_ROWS) * rtpl_pkg::BLOCK_WIDTH;

  logic [rtpl_pkg::HEIGHT_W-1:0] block_height_q, block_height_d;
  logic                          known;
  rtpl_pkg::cmd_t                cmd;
  logic                          q_full, push;
  logic                          head_valid, pop, init_busy;
  rtpl_pkg::cmd_t                head_cmd;

  assign cfg_ready_o    = 1'b1;
  assign block_height_d = (cfg_valid_i && cfg_ready_o) ? cfg_data_i : block_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_height_q <= rtpl_pkg::HEIGHT_W'(256);
    end else begin
      block_height_q <= block_height_d;
    end
  end

  rtpl_front #(
    .MaxBlockHeight (MaxBlockHeight),
    .StoreWords     (StoreWords)
  ) u_front (
    .mode_i         (mode_i),
    .pix_x_i        (pix_x_i),
    .pix_y_i        (pix_y_i),
    .word_index_i   (word_index_i),
    .write_data_i   (write_data_i),
    .block_height_i (block_height_q),
    .known_o        (known),
    .cmd_o          (cmd)
  );

  assign in_stall_o = q_full || init_busy;
  // unknown modes are accepted and dropped
  assign push       = in_valid_i && !in_stall_o && known;

  rtpl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_cmd_i   (cmd),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd)
  );

  rtpl_back #(
    .StoreWords (StoreWords)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_cmd_i     (head_cmd),
    .pop_o          (pop),
    .init_busy_o    (init_busy),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_data_o    (read_data_o),
    .bad_position_o (bad_position_o)
  );

endmodule

// ----- src/rtpl_ram.sv -----
// generic simple dual port ram, one write and one registered read port
// no dependencies
module rtpl_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rtpl_front.sv -----
// front end: decodes an item into a store command with addresses and flags
// depends on rtpl_pkg
module rtpl_front #(
  parameter int MaxBlockHeight = 256,
  parameter int StoreWords     = 81920
) (
  input  logic [rtpl_pkg::MODE_W-1:0]   mode_i,
  input  logic [rtpl_pkg::COORD_W-1:0]  pix_x_i,
  input  logic [rtpl_pkg::COORD_W-1:0]  pix_y_i,
  input  logic [rtpl_pkg::ADDR_W-1:0]   word_index_i,
  input  logic [rtpl_pkg::DATA_W-1:0]   write_data_i,
  input  logic [rtpl_pkg::HEIGHT_W-1:0] block_height_i,
  output logic                          known_o,
  output rtpl_pkg::cmd_t                cmd_o
);

  localparam logic [rtpl_pkg::HEIGHT_W-1:0] MaxH = rtpl_pkg::HEIGHT_W'(MaxBlockHeight);

  logic [rtpl_pkg::HEIGHT_W-1:0] height;
  logic                          row_ok;
  logic [rtpl_pkg::ADDR_W-1:0]   color_addr;
  logic [rtpl_pkg::ADDR_W-1:0]   alpha_addr;
  logic [rtpl_pkg::DATA_W-1:0]   color_word;

  assign height = (block_height_i > MaxH) ? MaxH : block_height_i;
  assign row_ok = {1'b0, pix_y_i} < height;

  assign color_addr = rtpl_pkg::ADDR_W'((int'(pix_y_i) + rtpl_pkg::ALPHA_ROWS)
                      * rtpl_pkg::BLOCK_WIDTH + int'(pix_x_i));
  // four rows share an alpha word row, one quarter row apart
  assign alpha_addr = rtpl_pkg::ADDR_W'(int'(pix_y_i[rtpl_pkg::COORD_W-1:2])
                      * rtpl_pkg::BLOCK_WIDTH
                      + rtpl_pkg::ALPHA_ROWS * int'(pix_y_i[1:0])
                      + int'(pix_x_i[rtpl_pkg::COORD_W-1:2]));

  // r,g,b,a in, stored as b,g,r,a
  assign color_word = {write_data_i[31:24], write_data_i[7:0],
                       write_data_i[15:8], write_data_i[23:16]};

  always_comb begin
    known_o         = 1'b1;
    cmd_o.op        = rtpl_pkg::mode_e'(mode_i);
    cmd_o.bad       = 1'b0;
    cmd_o.in_range  = word_index_i < rtpl_pkg::ADDR_W'(StoreWords);
    cmd_o.addr_a    = word_index_i;
    cmd_o.addr_b    = alpha_addr;
    cmd_o.lane      = pix_x_i[rtpl_pkg::LANE_W-1:0];
    cmd_o.data      = write_data_i;
    cmd_o.alpha     = write_data_i[31:24];
    unique case (mode_i)
      rtpl_pkg::MODE_WPIX: begin
        cmd_o.bad    = !row_ok;
        cmd_o.addr_a = color_addr;
        cmd_o.data   = color_word;
      end
      rtpl_pkg::MODE_RPIX: begin
        cmd_o.bad    = !row_ok;
        cmd_o.addr_a = color_addr;
      end
      rtpl_pkg::MODE_RWORD, rtpl_pkg::MODE_WWORD, rtpl_pkg::MODE_CLEAR: begin
      end
      default: begin
        known_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- src/rtpl_queue.sv -----
// two entry command queue between front and back
// depends on rtpl_pkg
module rtpl_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rtpl_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           head_valid_o,
  output rtpl_pkg::cmd_t head_cmd_o
);

  rtpl_pkg::cmd_t                entry_q [rtpl_pkg::QUEUE_DEPTH];
  logic [rtpl_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [rtpl_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [rtpl_pkg::QCNT_W-1:0]   count_q, count_d;

  assign full_o       = count_q == rtpl_pkg::QCNT_W'(rtpl_pkg::QUEUE_DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_cmd_o   = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

// ----- src/rtpl_back.sv -----
// back end: sequencer over the tile store ram, owns the result register
// depends on rtpl_pkg, rtpl_ram and the assertion macro header
`include "rgba_tile_plane_layout_codec_macros.svh"

module rtpl_back #(
  parameter int StoreWords = 81920
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        head_valid_i,
  input  rtpl_pkg::cmd_t              head_cmd_i,
  output logic                        pop_o,
  output logic                        init_busy_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rtpl_pkg::DATA_W-1:0] read_data_o,
  output logic                        bad_position_o
);

  localparam int AW = $clog2(StoreWords);
  localparam logic [AW-1:0] LastAddr = AW'(StoreWords - 1);

  typedef enum logic [4:0] {
    ST_INIT  = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_STEP2 = 5'b00100,
    ST_STEP3 = 5'b01000,
    ST_WIPE  = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  logic [AW-1:0]                 ptr_q, ptr_d;
  logic [rtpl_pkg::DATA_W-1:0]   color_q, color_d;
  logic                          out_valid_q, out_valid_d;
  logic [rtpl_pkg::DATA_W-1:0]   out_data_q, out_data_d;
  logic                          out_bad_q, out_bad_d;

  logic                          we, re;
  logic [AW-1:0]                 waddr, raddr;
  logic [rtpl_pkg::DATA_W-1:0]   wdata, rdata;
  logic                          out_free, emit;
  logic [rtpl_pkg::DATA_W-1:0]   res_data;
  logic                          res_bad;
  logic [rtpl_pkg::DATA_W-1:0]   merged;
  logic [rtpl_pkg::BYTE_W-1:0]   alpha_rd;

  rtpl_ram #(
    .Width (rtpl_pkg::DATA_W),
    .Depth (StoreWords)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign alpha_rd = rdata[head_cmd_i.lane*rtpl_pkg::BYTE_W +: rtpl_pkg::BYTE_W];

  always_comb begin
    merged = rdata;
    for (int i = 0; i < rtpl_pkg::LANES; i++) begin
      if (head_cmd_i.lane == rtpl_pkg::LANE_W'(i)) begin
        merged[i*rtpl_pkg::BYTE_W +: rtpl_pkg::BYTE_W] = head_cmd_i.alpha;
      end
    end
  end

  // a step that ends the item waits while the result register is held;
  // repeating its write in that time stores the same value again
  always_comb begin
    state_d  = state_q;
    ptr_d    = ptr_q;
    color_d  = color_q;
    we       = 1'b0;
    waddr    = head_cmd_i.addr_a[AW-1:0];
    wdata    = head_cmd_i.data;
    re       = 1'b0;
    raddr    = head_cmd_i.addr_a[AW-1:0];
    emit     = 1'b0;
    res_data = '0;
    res_bad  = 1'b0;
    unique case (state_q)
      ST_INIT: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = '0;
        ptr_d = ptr_q + 1'b1;
        if (ptr_q == LastAddr) begin
          ptr_d   = '0;
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_valid_i) begin
          case (head_cmd_i.op)
            rtpl_pkg::MODE_WPIX, rtpl_pkg::MODE_RPIX: begin
              if (head_cmd_i.bad) begin
                emit    = out_free;
                res_bad = 1'b1;
              end else begin
                we      = head_cmd_i.op == rtpl_pkg::MODE_WPIX;
                re      = 1'b1;
                raddr   = (head_cmd_i.op == rtpl_pkg::MODE_WPIX)
                          ? head_cmd_i.addr_b[AW-1:0] : head_cmd_i.addr_a[AW-1:0];
                state_d = ST_STEP2;
              end
            end
            rtpl_pkg::MODE_RWORD: begin
              if (head_cmd_i.in_range) begin
                re      = 1'b1;
                state_d = ST_STEP2;
              end else begin
                emit = out_free;
              end
            end
            rtpl_pkg::MODE_WWORD: begin
              we   = head_cmd_i.in_range;
              emit = out_free;
            end
            default: begin
              ptr_d   = '0;
              state_d = ST_WIPE;
            end
          endcase
        end
      end
      ST_STEP2: begin
        case (head_cmd_i.op)
          rtpl_pkg::MODE_WPIX: begin
            we    = 1'b1;
            waddr = head_cmd_i.addr_b[AW-1:0];
            wdata = merged;
            emit  = out_free;
          end
          rtpl_pkg::MODE_RPIX: begin
            color_d = rdata;
            re      = 1'b1;
            raddr   = head_cmd_i.addr_b[AW-1:0];
            state_d = ST_STEP3;
          end
          default: begin
            res_data = rdata;
            emit     = out_free;
          end
        endcase
      end
      ST_STEP3: begin
        // colour word holds b,g,r,a; result is r,g,b,a
        res_data = {alpha_rd, color_q[7:0], color_q[15:8], color_q[23:16]};
        emit     = out_free;
      end
      ST_WIPE: begin
        we    = 1'b1;
        waddr = ptr_q;
        wdata = '0;
        if (ptr_q != LastAddr) begin
          ptr_d = ptr_q + 1'b1;
        end else begin
          emit = out_free;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (emit) begin
      state_d = ST_IDLE;
      ptr_d   = '0;
    end
  end

  assign pop_o = emit;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_bad_d   = out_bad_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_data_d  = res_data;
      out_bad_d   = res_bad;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    color_q    <= color_d;
    out_data_q <= out_data_d;
    out_bad_q  <= out_bad_d;
  end

  assign init_busy_o    = state_q == ST_INIT;
  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_data_q;
  assign bad_position_o = out_bad_q;

  `RTPL_ASSERT_IMP(a_busy_has_item, (state_q == ST_STEP2 || state_q == ST_STEP3
    || state_q == ST_WIPE), head_valid_i, "sequencer busy with no queued item")
  `RTPL_ASSERT_IMP(a_pop_needs_slot, pop_o, head_valid_i && out_free,
    "item retired without a queued item or a free result slot")
  `RTPL_ASSERT_NXT(a_init_once, state_q != ST_INIT, state_q != ST_INIT,
    "clearing pass entered again after reset")
  `RTPL_ASSERT_IMP(a_port_split, we && re, waddr != raddr,
    "read and write of the same word in one cycle")

endmodule
